>>> hdl/pid_filtered_derivative_unit_defines.svh
// assertion helpers for the pid filtered derivative unit
`ifndef PID_FILTERED_DERIVATIVE_UNIT_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define PFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pfd_pkg.sv
package pfd_pkg;

  // sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_WRAPE,
    ST_WRAPE_W,
    ST_WRAPE_Q,
    ST_WRAPE_QW,
    ST_INTMUL,
    ST_INTMUL_W,
    ST_INTACC,
    ST_RAWDIV,
    ST_RAWDIV_W,
    ST_ALPDIV,
    ST_ALPDIV_W,
    ST_DMUL,
    ST_DMUL_W,
    ST_DSUM,
    ST_PMUL,
    ST_PMUL_W,
    ST_WRAPP,
    ST_WRAPP_W,
    ST_WRAPP_Q,
    ST_WRAPP_QW,
    ST_IMUL,
    ST_IMUL_W,
    ST_DTMUL,
    ST_DTMUL_W,
    ST_OUT
  } state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_WINDUP   = 3'd3,
    REG_ANGLE    = 3'd4,
    REG_FILTER   = 3'd5
  } reg_index_t;

  localparam int unsigned DivW = 64;
  localparam int unsigned MulW = 56;

endpackage

>>> hdl/pfd_mul.sv
// sequential signed multiplier, two bits per cycle (radix-4 shift and add)
module pfd_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [pfd_pkg::MulW-1:0] a,
  input  logic signed [pfd_pkg::MulW-1:0] b,
  output logic                         done,
  output logic signed [2*pfd_pkg::MulW-1:0] prod
);
  localparam int unsigned W = pfd_pkg::MulW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]   mag_b;
  logic [2*W-1:0] mag_a;
  logic [2*W-1:0] acc;
  logic           neg;
  logic           busy;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] step_sum;

  always_comb begin
    step_sum = acc;
    if (mag_b[0]) step_sum = step_sum + mag_a;
    if (mag_b[1]) step_sum = step_sum + (mag_a << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt >= CW'(W / 2 - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_a <= (2*W)'(a[W-1] ? -a : a);
      mag_b <= b[W-1] ? W'(-b) : W'(b);
      neg   <= a[W-1] ^ b[W-1];
      acc   <= '0;
    end else if (busy) begin
      acc   <= step_sum;
      mag_a <= mag_a << 2;
      mag_b <= mag_b >> 2;
    end
  end

  assign prod = neg ? -$signed(acc) : $signed(acc);
endmodule

>>> hdl/pfd_div.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
module pfd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [pfd_pkg::DivW-1:0]  num,
  input  logic signed [pfd_pkg::DivW-1:0]  den,
  output logic                             done,
  output logic signed [pfd_pkg::DivW-1:0]  quo
);
  localparam int unsigned W = pfd_pkg::DivW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  d;
  logic          qneg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;

  assign trial = {r, q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= num[W-1] ? W'(-num) : W'(num);
      d    <= den[W-1] ? W'(-den) : W'(den);
      r    <= '0;
      qneg <= num[W-1] ^ den[W-1];
    end else if (busy) begin
      if (!trial[W]) begin
        r <= trial[W-1:0];
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= {r[W-2:0], q[W-1]};
        q <= {q[W-2:0], 1'b0};
      end
    end
  end

  assign quo = qneg ? -$signed(q) : $signed(q);
endmodule

>>> hdl/pid_filtered_derivative_unit.sv
// pid step with filtered derivative, one channel, iterative datapath
// five multiplies on one shared multiplier and two divides on one shared divider;
// each angle wrap adds two multiplies
// one step at a time: in_ready low while busy and while a result waits for out_ready
// reset: synchronous, active high; clears state, gains and sets filter rc default
`include "pid_filtered_derivative_unit_defines.svh"

module pid_filtered_derivative_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] command,
  input  logic signed [31:0] measured,
  input  logic [15:0] time_step,
  input  logic        hold_integral,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] drive
);
  localparam int unsigned DW = pfd_pkg::DivW;
  localparam int unsigned MW = pfd_pkg::MulW;
  localparam longint unsigned PiQ32 = 64'd13493037705;
  localparam longint unsigned RcQ32 = (64'd683565276 + 64'd10) / 64'd20;
  localparam longint PiQ = longint'((PiQ32 + (64'd1 << (31 - FRACTION_BITS)))
                                    >> (32 - FRACTION_BITS));
  localparam longint RcReset = longint'((RcQ32 + (64'd1 << (31 - FRACTION_BITS)))
                                        >> (32 - FRACTION_BITS));
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  // angle wrap by reciprocal multiply: q = floor(y * RecipQ / 2^RecipShift)
  // is off by at most one for |y| < 2^(63 - FRACTION_BITS)
  localparam longint TwoPiQ = 2 * PiQ;
  localparam int unsigned RecipShift = 62 - FRACTION_BITS;
  localparam longint RecipQ = longint'(((64'd1 << RecipShift) + 64'(TwoPiQ / 2))
                                       / 64'(TwoPiQ));

  // configuration registers
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic [30:0]        windup_limit, filter_time_constant;
  logic               angle_mode;

  // state kept between steps
  logic signed [31:0] integral, last_error, deriv_prev1, deriv_prev2;

  // per-step working registers
  logic signed [31:0] cmd_q, meas_q, err, raw, deriv, dsum, pterm;
  logic [15:0]        dt;
  logic               hold;
  logic signed [DW-1:0] alpha;
  logic signed [DW-1:0] acc_sum;
  logic signed [DW-1:0] wrap_y, wrap_q;

  pfd_pkg::state_t state, state_next;

  // shared units
  logic                  mul_start, mul_done;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic                  div_start, div_done;
  logic signed [DW-1:0]  div_num, div_den, div_quo;

  pfd_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod(mul_p));
  pfd_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
                 .done(div_done), .quo(div_quo));

  function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] x);
    if (x > S32Max) return 32'sh7fffffff;
    if (x < S32Min) return 32'sh80000000;
    return x[31:0];
  endfunction

  // floor shift of product: arithmetic shift rounds toward minus infinity
  logic signed [DW-1:0] mul_fs;
  assign mul_fs = DW'(mul_p >>> FRACTION_BITS);

  // y - q * 2pi brought into [0, 2pi) by one step, then shifted to [-pi, pi)
  logic signed [DW-1:0] wrap_rem, wrap_out;
  always_comb begin
    wrap_rem = wrap_y - DW'(mul_p);
    if (wrap_rem < 0) wrap_rem = wrap_rem + TwoPiQ;
    else if (wrap_rem >= TwoPiQ) wrap_rem = wrap_rem - TwoPiQ;
    wrap_out = wrap_rem - PiQ;
  end

  logic signed [DW-1:0] den_alpha, int_acc, lim;
  assign den_alpha = DW'(filter_time_constant) + DW'(dt);
  assign lim       = DW'(windup_limit);
  always_comb begin
    int_acc = DW'(sat32(DW'(integral) + mul_fs));
    if (int_acc > lim) int_acc = lim;
    if (int_acc < -lim) int_acc = -lim;
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == pfd_pkg::ST_IDLE) && !out_valid;

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      pfd_pkg::ST_IDLE:     if (in_valid && in_ready) state_next = pfd_pkg::ST_ERR;
      pfd_pkg::ST_ERR:      state_next = angle_mode ? pfd_pkg::ST_WRAPE : pfd_pkg::ST_INTMUL;
      pfd_pkg::ST_WRAPE:    state_next = pfd_pkg::ST_WRAPE_W;
      pfd_pkg::ST_WRAPE_W:  if (mul_done) state_next = pfd_pkg::ST_WRAPE_Q;
      pfd_pkg::ST_WRAPE_Q:  state_next = pfd_pkg::ST_WRAPE_QW;
      pfd_pkg::ST_WRAPE_QW: if (mul_done) state_next = pfd_pkg::ST_INTMUL;
      pfd_pkg::ST_INTMUL:   state_next = pfd_pkg::ST_INTMUL_W;
      pfd_pkg::ST_INTMUL_W: if (mul_done) state_next = pfd_pkg::ST_INTACC;
      pfd_pkg::ST_INTACC:   state_next = pfd_pkg::ST_RAWDIV;
      pfd_pkg::ST_RAWDIV:   state_next = (dt != '0) ? pfd_pkg::ST_RAWDIV_W
                                                    : pfd_pkg::ST_ALPDIV;
      pfd_pkg::ST_RAWDIV_W: if (div_done) state_next = pfd_pkg::ST_ALPDIV;
      pfd_pkg::ST_ALPDIV:   state_next = (den_alpha != '0) ? pfd_pkg::ST_ALPDIV_W
                                                           : pfd_pkg::ST_DMUL;
      pfd_pkg::ST_ALPDIV_W: if (div_done) state_next = pfd_pkg::ST_DMUL;
      pfd_pkg::ST_DMUL:     state_next = pfd_pkg::ST_DMUL_W;
      pfd_pkg::ST_DMUL_W:   if (mul_done) state_next = pfd_pkg::ST_DSUM;
      pfd_pkg::ST_DSUM:     state_next = pfd_pkg::ST_PMUL;
      pfd_pkg::ST_PMUL:     state_next = pfd_pkg::ST_PMUL_W;
      pfd_pkg::ST_PMUL_W:   if (mul_done) state_next = angle_mode ? pfd_pkg::ST_WRAPP
                                                                  : pfd_pkg::ST_IMUL;
      pfd_pkg::ST_WRAPP:    state_next = pfd_pkg::ST_WRAPP_W;
      pfd_pkg::ST_WRAPP_W:  if (mul_done) state_next = pfd_pkg::ST_WRAPP_Q;
      pfd_pkg::ST_WRAPP_Q:  state_next = pfd_pkg::ST_WRAPP_QW;
      pfd_pkg::ST_WRAPP_QW: if (mul_done) state_next = pfd_pkg::ST_IMUL;
      pfd_pkg::ST_IMUL:     state_next = pfd_pkg::ST_IMUL_W;
      pfd_pkg::ST_IMUL_W:   if (mul_done) state_next = pfd_pkg::ST_DTMUL;
      pfd_pkg::ST_DTMUL:    state_next = pfd_pkg::ST_DTMUL_W;
      pfd_pkg::ST_DTMUL_W:  if (mul_done) state_next = pfd_pkg::ST_OUT;
      pfd_pkg::ST_OUT:      state_next = pfd_pkg::ST_IDLE;
      default:              state_next = pfd_pkg::ST_IDLE;
    endcase
  end

  // unit launch controls
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_num = '0;
    div_den = 64'sd1;
    unique case (state)
      pfd_pkg::ST_WRAPE: begin
        mul_start = 1'b1;
        mul_a = MW'(DW'(err) + PiQ);
        mul_b = MW'(RecipQ);
      end
      pfd_pkg::ST_WRAPE_Q, pfd_pkg::ST_WRAPP_Q: begin
        mul_start = 1'b1;
        mul_a = MW'(wrap_q);
        mul_b = MW'(TwoPiQ);
      end
      pfd_pkg::ST_INTMUL: begin
        mul_start = 1'b1;
        mul_a = MW'(err);
        mul_b = MW'($signed({1'b0, dt}));
      end
      pfd_pkg::ST_RAWDIV: begin
        div_start = (dt != '0);
        div_num = (DW'(err) - DW'(last_error)) <<< FRACTION_BITS;
        div_den = DW'(dt);
      end
      pfd_pkg::ST_ALPDIV: begin
        div_start = (den_alpha != '0);
        div_num = DW'(dt) <<< FRACTION_BITS;
        div_den = den_alpha;
      end
      pfd_pkg::ST_DMUL: begin
        mul_start = 1'b1;
        mul_a = MW'(DW'(raw) - DW'(last_error));
        mul_b = MW'(alpha);
      end
      pfd_pkg::ST_PMUL: begin
        mul_start = 1'b1;
        mul_a = MW'(gain_p);
        mul_b = MW'(err);
      end
      pfd_pkg::ST_WRAPP: begin
        mul_start = 1'b1;
        mul_a = MW'(acc_sum + PiQ);
        mul_b = MW'(RecipQ);
      end
      pfd_pkg::ST_IMUL: begin
        mul_start = 1'b1;
        mul_a = MW'(gain_i);
        mul_b = MW'(integral);
      end
      pfd_pkg::ST_DTMUL: begin
        mul_start = 1'b1;
        mul_a = MW'(gain_d);
        mul_b = MW'(dsum);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      windup_limit <= '0;
      angle_mode <= 1'b0;
      filter_time_constant <= 31'(RcReset);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfd_pkg::REG_GAIN_P: gain_p <= cfg_data;
        pfd_pkg::REG_GAIN_I: gain_i <= cfg_data;
        pfd_pkg::REG_GAIN_D: gain_d <= cfg_data;
        pfd_pkg::REG_WINDUP: windup_limit <= cfg_data[30:0];
        pfd_pkg::REG_ANGLE:  angle_mode <= cfg_data[0];
        pfd_pkg::REG_FILTER: filter_time_constant <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // loop state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      last_error <= '0;
      deriv_prev1 <= '0;
      deriv_prev2 <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == pfd_pkg::ST_INTACC && !hold) integral <= int_acc[31:0];
      if (state == pfd_pkg::ST_DSUM) begin
        last_error <= err;
        deriv_prev2 <= deriv_prev1;
        deriv_prev1 <= deriv;
      end
      if (state == pfd_pkg::ST_OUT) out_valid <= 1'b1;
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    unique case (state)
      pfd_pkg::ST_IDLE: begin
        cmd_q <= command;
        meas_q <= measured;
        dt <= time_step;
        hold <= hold_integral;
      end
      pfd_pkg::ST_ERR: begin
        err <= sat32(DW'(cmd_q) - DW'(meas_q));
        raw <= '0;
        alpha <= '0;
      end
      pfd_pkg::ST_WRAPE: wrap_y <= DW'(err) + PiQ;
      pfd_pkg::ST_WRAPP: wrap_y <= acc_sum + PiQ;
      pfd_pkg::ST_WRAPE_W, pfd_pkg::ST_WRAPP_W:
        if (mul_done) wrap_q <= DW'(mul_p >>> RecipShift);
      pfd_pkg::ST_WRAPE_QW: if (mul_done) err <= wrap_out[31:0];
      pfd_pkg::ST_RAWDIV_W: if (div_done) raw <= sat32(div_quo);
      pfd_pkg::ST_ALPDIV_W: if (div_done) alpha <= div_quo;
      pfd_pkg::ST_DMUL_W: if (mul_done) deriv <= sat32(DW'(last_error) + mul_fs);
      pfd_pkg::ST_DSUM:
        dsum <= sat32(DW'(deriv) + DW'(deriv_prev1) + DW'(deriv_prev2));
      pfd_pkg::ST_PMUL_W: if (mul_done) begin
        acc_sum <= mul_fs;
        pterm <= sat32(mul_fs);
      end
      pfd_pkg::ST_WRAPP_QW: if (mul_done) pterm <= sat32(wrap_out);
      pfd_pkg::ST_IMUL_W: if (mul_done) acc_sum <= DW'(pterm) + mul_fs;
      pfd_pkg::ST_DTMUL_W: if (mul_done) drive <= sat32(acc_sum + mul_fs);
      default: ;
    endcase
  end

  `PFD_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != pfd_pkg::ST_IDLE, !in_ready, "accept while busy")
  `PFD_ASSERT_NEXT(a_out_after_step, clk, rst, state == pfd_pkg::ST_OUT, out_valid, "result not raised")
  `PFD_ASSERT_IMPL(a_one_unit, clk, rst, mul_start, !div_start, "both units launched")
  `PFD_ASSERT_NEXT(a_windup, clk, rst, state == pfd_pkg::ST_INTACC && !hold, integral <= lim && integral >= -lim, "integral over limit")
endmodule

>>> tb/pid_filtered_derivative_unit_checker.sv
module pid_filtered_derivative_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] command,
  input  logic signed [31:0] measured,
  input  logic [15:0]        time_step,
  input  logic               hold_integral,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] drive,
  output int                 error_count,
  output int                 pending_drives
);
  localparam int FB = 16;
  localparam longint PI_FIX = 64'sd205887;
  localparam longint RC_DEFAULT = 64'sd522;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  longint kp, ki, kd, wind_lim, rc_const;
  bit     wrap_on;
  longint integ, prev_err, dhist1, dhist2;
  logic signed [31:0] drive_queue[$];

  function automatic longint clamp32(input longint x);
    if (x > S32_HI) return S32_HI;
    if (x < S32_LO) return S32_LO;
    return x;
  endfunction

  // arithmetic shift floors toward minus infinity
  function automatic longint fix_mul(input longint a, input longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint wrap_pi(input longint x);
    longint span, r;
    span = 2 * PI_FIX;
    r = (x + PI_FIX) % span;
    if (r < 0) r += span;
    return r - PI_FIX;
  endfunction

  function automatic logic signed [31:0] pid_drive(input longint cmd, input longint meas,
                                                   input longint dt, input bit hold);
    longint e, acc, raw, alpha, den, d, dsum, pt, it, dt_term;
    e = clamp32(cmd - meas);
    if (wrap_on) e = wrap_pi(e);
    if (!hold) begin
      acc = clamp32(integ + fix_mul(e, dt));
      if (acc > wind_lim) acc = wind_lim;
      if (acc < -wind_lim) acc = -wind_lim;
      integ = acc;
    end
    raw = (dt != 0) ? clamp32(((e - prev_err) * (64'sd1 <<< FB)) / dt) : 0;
    den = rc_const + dt;
    alpha = (den != 0) ? (dt * (64'sd1 <<< FB)) / den : 0;
    d = clamp32(prev_err + fix_mul(raw - prev_err, alpha));
    prev_err = e;
    dsum = clamp32(d + dhist1 + dhist2);
    dhist2 = dhist1;
    dhist1 = d;
    pt = fix_mul(kp, e);
    if (wrap_on) pt = wrap_pi(pt);
    pt = clamp32(pt);
    it = fix_mul(ki, integ);
    dt_term = fix_mul(kd, dsum);
    return 32'(clamp32(pt + it + dt_term));
  endfunction

  assign pending_drives = drive_queue.size();

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst) begin
      kp = 0; ki = 0; kd = 0; wind_lim = 0; wrap_on = 0; rc_const = RC_DEFAULT;
      integ = 0; prev_err = 0; dhist1 = 0; dhist2 = 0;
      drive_queue.delete();
      error_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pfd_pkg::REG_GAIN_P: kp = longint'(signed'(cfg_data));
          pfd_pkg::REG_GAIN_I: ki = longint'(signed'(cfg_data));
          pfd_pkg::REG_GAIN_D: kd = longint'(signed'(cfg_data));
          pfd_pkg::REG_WINDUP: wind_lim = longint'(cfg_data[30:0]);
          pfd_pkg::REG_ANGLE:  wrap_on = cfg_data[0];
          pfd_pkg::REG_FILTER: rc_const = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_queue.push_back(pid_drive(longint'(command), longint'(measured),
                                        longint'(time_step), hold_integral));
      if (out_valid && out_ready) begin
        if (drive_queue.size() == 0) begin
          if (error_count < 10) $display("unexpected drive %0d", drive);
          error_count <= error_count + 1;
        end else begin
          want = drive_queue.pop_front();
          if (want !== drive) begin
            if (error_count < 10) $display("drive mismatch: expected %0d got %0d", want, drive);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/pid_filtered_derivative_unit_tb.sv
module pid_filtered_derivative_unit_tb;
  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] command = '0;
  logic signed [31:0] measured = '0;
  logic [15:0] time_step = 16'd1;
  logic hold_integral = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] drive;
  int error_count, pending_drives;

  // receiver modes: long hold-off request
  bit hold_off_req = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  pid_filtered_derivative_unit uut (.*);

  pid_filtered_derivative_unit_checker chk (.*);

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls per transfer, plus one long hold-off
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_off_req = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_reg(input pfd_pkg::reg_index_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_step(input logic [31:0] c, input logic [31:0] m,
                           input logic [15:0] dt, input logic h, input bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 9);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    command <= c;
    measured <= m;
    time_step <= dt;
    hold_integral <= h;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_drives != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // random field with bias toward extremes and small values
  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 600000)) - 300000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(0, 3))
      0: return 16'(($urandom_range(0, 1) == 1) ? 16'hffff : 16'd1);
      1: return 16'($urandom_range(1, 2000));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic config_phase(input int sel);
    case (sel)
      0: begin
        write_reg(pfd_pkg::REG_GAIN_P, 32'h00010000);
        write_reg(pfd_pkg::REG_GAIN_I, 32'h00008000);
        write_reg(pfd_pkg::REG_GAIN_D, 32'h00004000);
        write_reg(pfd_pkg::REG_WINDUP, 32'h00640000);
        write_reg(pfd_pkg::REG_ANGLE, 32'd0);
      end
      1: begin
        // extremes of every register
        write_reg(pfd_pkg::REG_GAIN_P, 32'h7fffffff);
        write_reg(pfd_pkg::REG_GAIN_I, 32'h80000000);
        write_reg(pfd_pkg::REG_GAIN_D, 32'h7fffffff);
        write_reg(pfd_pkg::REG_WINDUP, 32'h7fffffff);
        write_reg(pfd_pkg::REG_ANGLE, 32'd1);
        write_reg(pfd_pkg::REG_FILTER, 32'h7fffffff);
      end
      2: begin
        write_reg(pfd_pkg::REG_GAIN_P, 32'h80000000);
        write_reg(pfd_pkg::REG_GAIN_I, 32'h7fffffff);
        write_reg(pfd_pkg::REG_GAIN_D, 32'h80000000);
        write_reg(pfd_pkg::REG_WINDUP, 32'd0);
        write_reg(pfd_pkg::REG_ANGLE, 32'd0);
        write_reg(pfd_pkg::REG_FILTER, 32'd0);
      end
      default: begin
        write_reg(pfd_pkg::REG_GAIN_P, $urandom);
        write_reg(pfd_pkg::REG_GAIN_I, $urandom);
        write_reg(pfd_pkg::REG_GAIN_D, $urandom);
        write_reg(pfd_pkg::REG_WINDUP, $urandom);
        write_reg(pfd_pkg::REG_ANGLE, $urandom);
        write_reg(pfd_pkg::REG_FILTER, ($urandom_range(0, 1) == 1)
                                       ? 32'($urandom_range(0, 4000)) : $urandom);
      end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: default filter rc with zero gains first, then extremes
    send_step(32'd0, 32'd0, 16'd1, 1'b0, 0);
    drain();
    config_phase(0);
    send_step(32'h7fffffff, 32'h80000000, 16'hffff, 1'b0, 0);
    send_step(32'h80000000, 32'h7fffffff, 16'd1, 1'b0, 0);
    send_step(32'h00010000, 32'd0, 16'h8000, 1'b1, 0);
    send_step(32'hffffffff, 32'h00000001, 16'd1, 1'b0, 0);
    drain();
    config_phase(1);
    // angle wrap around plus and minus pi
    send_step(32'd205887, 32'd0, 16'd100, 1'b0, 0);
    send_step(32'd0, 32'd205887, 16'd100, 1'b0, 0);
    send_step(32'h7fffffff, 32'h80000000, 16'hffff, 1'b1, 0);
    send_step(32'h80000000, 32'h7fffffff, 16'd1, 1'b0, 0);
    drain();
    config_phase(2);
    // zero rc: alpha near full scale
    send_step(32'h40000000, 32'hc0000000, 16'd1, 1'b0, 0);
    send_step(32'hc0000000, 32'h40000000, 16'hffff, 1'b0, 0);
    send_step(32'd12345, 32'd54321, 16'd7, 1'b1, 0);
    drain();

    // random phases, each with fresh settings
    for (int ph = 0; ph < 11; ph++) begin
      config_phase((ph % 4 == 3) ? 1 : 3);
      if (ph == 5) hold_off_req = 1;
      for (int k = 0; k < 100; k++)
        send_step(pick_val(), pick_val(), pick_dt(), 1'($urandom_range(0, 1)),
                  (ph == 5) || (ph == 7 && k < 50));
      drain();
    end

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/pfd_pkg.sv
hdl/pfd_mul.sv
hdl/pfd_div.sv
hdl/pid_filtered_derivative_unit.sv
tb/pid_filtered_derivative_unit_checker.sv
tb/pid_filtered_derivative_unit_tb.sv
